// ===== rtl/cimw_pkg.sv =====
// Shared constants, request codes and the character fold for the wildcard matcher.
// No dependencies; cimw_if, cimw_lanes, cimw_nfa and the core import this package.
`default_nettype none

package cimw_pkg;

    // Field widths of the request and configuration ports.
    localparam int CHAR_W = 16;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;

    // Default number of pattern slots.
    localparam int MAX_PATTERN_DEF = 64;

    // Character constants.
    localparam logic [CHAR_W-1:0] CH_STAR     = 16'h002A;
    localparam logic [CHAR_W-1:0] CH_QMARK    = 16'h003F;
    localparam logic [CHAR_W-1:0] CH_LOWER_A  = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 16'h007A;
    localparam logic [CHAR_W-1:0] ASCII_LIMIT = 16'h0080;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'h0020;

    // Request codes; code 3 is unused.
    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_SUBJECT = 2'd1,
        REQ_QUERY   = 2'd2
    } t_req;

    // Fold ASCII a..z to A..Z; everything else passes unchanged.
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        if (c < ASCII_LIMIT && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cimw_if.sv =====
// Request and result channel interfaces for the wildcard matcher.
// Depends on cimw_pkg for the field widths.
`default_nettype none

interface cimw_req_if import cimw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic              last;

    modport source (output valid, req_type, char_code, position, last, input ready);
    modport sink   (input valid, req_type, char_code, position, last, output ready);
endinterface

interface cimw_res_if;
    logic valid;
    logic ready;
    logic matched;
    logic subject_done;

    modport source (output valid, matched, subject_done, input ready);
    modport sink   (input valid, matched, subject_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/cimw_lanes.sv =====
// Pattern slot lanes: one stored, folded character per slot and its comparator.
// Depends on cimw_pkg for widths, character constants and the fold function.
`default_nettype none

module cimw_lanes import cimw_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_load,
    input  wire logic [POS_W-1:0]       i_pos,
    input  wire logic [CHAR_W-1:0]      i_code,
    output logic      [MAX_PATTERN-1:0] o_star,
    output logic      [MAX_PATTERN-1:0] o_adv
);

    logic [CHAR_W-1:0] r_char [MAX_PATTERN];
    logic              r_star [MAX_PATTERN];
    logic              r_qmark[MAX_PATTERN];
    logic [CHAR_W-1:0] subj_fold;

    assign subj_fold = fold_char(i_code);

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (i_load && 32'(i_pos) == k) begin
                r_char[k]  <= subj_fold;
                r_star[k]  <= (i_code == CH_STAR);
                r_qmark[k] <= (i_code == CH_QMARK);
            end
        end

        // A slot advances on a '?' or on an equal folded character; a star never advances.
        assign o_star[k] = r_star[k];
        assign o_adv[k]  = !r_star[k] && (r_qmark[k] || r_char[k] == subj_fold);
    end

endmodule

`default_nettype wire

// ===== rtl/cimw_closure.sv =====
// Star closure as a parallel prefix network over the NFA positions.
// No package dependencies.
`default_nettype none

module cimw_closure #(
    parameter int N = 65
) (
    input  wire logic [N-1:0] i_set,
    input  wire logic [N-1:0] i_prop,
    output logic      [N-1:0] o_set
);

    localparam int L = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] g[L+1];
    logic [N-1:0] p[L+1];

    // Bit j ends active if some active bit k <= j reaches it through propagating bits.
    always_comb begin
        g[0] = i_set;
        p[0] = i_prop;
        for (int l = 0; l < L; l++) begin
            for (int j = 0; j < N; j++) begin
                if (j >= (1 << l)) begin
                    g[l+1][j] = g[l][j] | (p[l][j] & g[l][j-(1<<l)]);
                    p[l+1][j] = p[l][j] & p[l][j-(1<<l)];
                end else begin
                    g[l+1][j] = g[l][j];
                    p[l+1][j] = p[l][j];
                end
            end
        end
    end

    assign o_set = g[L];

endmodule

`default_nettype wire

// ===== rtl/cimw_nfa.sv =====
// Active position register of the NFA with its one-character step and match output.
// Depends on cimw_closure; no package items needed beyond the default size.
`default_nettype none

module cimw_nfa import cimw_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    localparam int LW = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_rearm,
    input  wire logic [LW-1:0]          i_len,
    input  wire logic [MAX_PATTERN-1:0] i_star,
    input  wire logic [MAX_PATTERN-1:0] i_adv,
    output logic                        o_step_match,
    output logic                        o_query_match
);

    localparam int N = MAX_PATTERN + 1;

    logic [N-1:0]           r_active;
    logic [N-1:0]           n_active;
    logic [N-1:0]           len_mask;
    logic [MAX_PATTERN-1:0] in_use;
    logic [N-1:0]           prop;
    logic [N-1:0]           cur;
    logic [N-1:0]           nxt_raw;
    logic [N-1:0]           nxt;
    logic [N-1:0]           start;
    logic [N-1:0]           query;

    always_comb begin
        for (int j = 0; j < N; j++) begin
            len_mask[j] = (32'(j) <= 32'(i_len));
        end
        for (int i = 0; i < MAX_PATTERN; i++) begin
            in_use[i] = (32'(i) < 32'(i_len));
        end
    end

    // A star in use at slot i carries activity from position i into i + 1.
    assign prop  = {i_star & in_use, 1'b0};
    assign start = N'(1);

    cimw_closure #(.N(N)) u_cur (
        .i_set  (r_active & len_mask),
        .i_prop (prop),
        .o_set  (cur)
    );

    always_comb begin
        nxt_raw = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (cur[i] && in_use[i]) begin
                if (i_star[i]) begin
                    nxt_raw[i] = 1'b1;
                end
                if (i_adv[i]) begin
                    nxt_raw[i+1] = 1'b1;
                end
            end
        end
    end

    cimw_closure #(.N(N)) u_nxt (
        .i_set  (nxt_raw),
        .i_prop (prop),
        .o_set  (nxt)
    );

    cimw_closure #(.N(N)) u_query (
        .i_set  (start),
        .i_prop (prop),
        .o_set  (query)
    );

    assign o_step_match  = (i_len == '0) || nxt[i_len];
    assign o_query_match = (i_len == '0) || query[i_len];

    always_comb begin
        n_active = r_active;
        if (i_rearm) begin
            n_active = start;
        end else if (i_step) begin
            n_active = nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= start;
        end else begin
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/case_insensitive_wildcard_matcher_core.sv =====
// Top level of the case-insensitive wildcard matcher: request register, NFA and result register.
// Depends on cimw_pkg, cimw_if, cimw_lanes, cimw_closure and cimw_nfa.
`default_nettype none

//  Channel  | Direction | Carries
//  ---------+-----------+-----------------------------------------------
//  i_req    | in        | req_type, char_code, position, last
//  o_res    | out       | matched, subject_done
//  i_cfg_*  | in        | pattern_length write (o_cfg_ready always high)
//
// Every request yields exactly one result. A request is taken every cycle unless the
// result register is stalled with the request register full: it first lands in a
// request register, from which the lanes compare it against all pattern slots at once
// while the NFA advances all positions together; the result register then holds the
// answer.
// The request register and the result register form a two-entry buffer, so requests
// keep flowing while one result is stalled; a stall of two results holds off i_req.
// Reset (synchronous, active low) empties both registers, sets the pattern length to
// zero and arms the NFA at position zero. Pattern slots are undefined until loaded.

module case_insensitive_wildcard_matcher_core import cimw_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    cimw_req_if.sink              i_req,
    cimw_res_if.source            o_res,
    input  wire logic             i_cfg_valid,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    localparam int LW = $clog2(MAX_PATTERN + 1);

    // Configuration register, saturated to the slot count when used.
    logic [LEN_W-1:0] r_cfg_len;
    logic [LW-1:0]    len;

    // Request register.
    logic              r_s1_valid;
    logic [1:0]        r_s1_req;
    logic [CHAR_W-1:0] r_s1_code;
    logic [POS_W-1:0]  r_s1_pos;
    logic              r_s1_last;

    // Result register.
    logic r_out_valid;
    logic r_out_matched;
    logic r_out_done;
    logic n_out_matched;
    logic n_out_done;

    logic                   s1_adv;
    logic                   do_load;
    logic                   do_subject;
    logic                   do_query;
    logic [MAX_PATTERN-1:0] star_vec;
    logic [MAX_PATTERN-1:0] adv_vec;
    logic                   step_match;
    logic                   query_match;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= '0;
        end else if (i_cfg_valid) begin
            r_cfg_len <= i_cfg_data;
        end
    end

    always_comb begin
        if (32'(r_cfg_len) > 32'(MAX_PATTERN)) begin
            len = LW'(MAX_PATTERN);
        end else begin
            len = LW'(r_cfg_len);
        end
    end

    // The request register moves on whenever the result register is free or being drained.
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_s1_req  <= i_req.req_type;
            r_s1_code <= i_req.char_code;
            r_s1_pos  <= i_req.position;
            r_s1_last <= i_req.last;
        end
    end

    assign do_load    = s1_adv && (r_s1_req == REQ_LOAD);
    assign do_subject = s1_adv && (r_s1_req == REQ_SUBJECT);
    assign do_query   = s1_adv && (r_s1_req == REQ_QUERY);

    // Loads land in the slot lanes; slots at or beyond the slot count are ignored there.
    cimw_lanes #(.MAX_PATTERN(MAX_PATTERN)) u_lanes (
        .i_clk  (i_clk),
        .i_load (do_load),
        .i_pos  (r_s1_pos),
        .i_code (r_s1_code),
        .o_star (star_vec),
        .o_adv  (adv_vec)
    );

    // A query, or the last character of a subject, rearms the NFA at position zero.
    cimw_nfa #(.MAX_PATTERN(MAX_PATTERN)) u_nfa (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (do_subject),
        .i_rearm       (do_query || (do_subject && r_s1_last)),
        .i_len         (len),
        .i_star        (star_vec),
        .i_adv         (adv_vec),
        .o_step_match  (step_match),
        .o_query_match (query_match)
    );

    // Loads and the unused request code report zeros.
    always_comb begin
        unique case (r_s1_req)
            REQ_SUBJECT: begin
                n_out_matched = step_match;
                n_out_done    = r_s1_last;
            end
            REQ_QUERY: begin
                n_out_matched = query_match;
                n_out_done    = 1'b1;
            end
            default: begin
                n_out_matched = 1'b0;
                n_out_done    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_res.ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_matched <= n_out_matched;
            r_out_done    <= n_out_done;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.matched      = r_out_matched;
    assign o_res.subject_done = r_out_done;

endmodule

`default_nettype wire

// ===== tb/case_insensitive_wildcard_matcher_core_tb.sv =====
// Self-checking testbench for the case-insensitive wildcard matcher core.
// Uses cimw_pkg and the channel interfaces of cimw_if; drives the core through them
// and checks every result against a bit-parallel glob predictor kept inside the bench.
`timescale 1ns / 1ps

module case_insensitive_wildcard_matcher_core_tb;
    import cimw_pkg::*;

    localparam int SLOTS        = MAX_PATTERN_DEF;
    localparam int TOTAL_ITEMS  = 1250;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 80;
    localparam int MAX_REPORTS  = 100;
    localparam int DIR_ROWS     = 26;

    // Only position zero is live when the NFA is armed.
    localparam logic [SLOTS:0] NFA_START = (SLOTS + 1)'(1);

    // Request code 3 has no meaning; the core must answer it with an all-zero result.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic matched;
        logic done;
    } t_match_res;

    // Per-request note from the sender: a directed row may carry its own answer.
    typedef struct packed {
        logic       fixed;
        t_match_res res;
    } t_fixed_hint;

    // One row of the directed table. For a length write, char_code carries the value.
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  rt;
        logic [15:0] cc;
        logic [5:0]  ps;
        logic        lst;
        logic        fixed;
        logic        em;
        logic        ed;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic [LEN_W-1:0] cfg_data;
    logic cfg_ready;

    cimw_req_if req_if ();
    cimw_res_if res_if ();

    case_insensitive_wildcard_matcher_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always #2 clk = ~clk;

    // Predictor state: the pattern slots, the set of live NFA positions and the length.
    logic [15:0]    glob_pattern [SLOTS];
    logic [SLOTS:0] nfa_active = NFA_START;
    logic [6:0]     glob_len   = '0;

    t_match_res  match_expect_q [$];
    t_fixed_hint fixed_hint_q [$];

    // Pattern of the current traffic phase, used to build subjects that should match.
    logic [15:0] phase_pat [SLOTS];
    logic [15:0] subject_buf [$];

    int error_count     = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    int cycle_count     = 0;
    int phase_count     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    // The stimulus asks for a long receiver hold by bumping hold_asks; the receiver
    // process notices the change and counts the hold down on its own.
    int hold_asks  = 0;
    int hold_taken = 0;
    int hold_left  = 0;

    t_dir_row dir_tab [DIR_ROWS];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Only ASCII a..z fold; everything else, including code units above 0x7F, is exact.
    function automatic logic [15:0] to_upper(input logic [15:0] c);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    // Clear positions past the pattern end, then let every live star also enable its
    // successor. The walk goes upward, so a run of stars opens up in a single pass.
    function automatic logic [SLOTS:0] star_spread(input logic [SLOTS:0] s, input int len);
        logic [SLOTS:0] r;
        int i;
        r = s;
        for (i = len + 1; i <= SLOTS; i++) begin
            r[i] = 1'b0;
        end
        for (i = 0; i < len; i++) begin
            if (r[i] && glob_pattern[i] == CH_STAR) begin
                r[i + 1] = 1'b1;
            end
        end
        return r;
    endfunction

    // Advance the glob NFA by one request and return the result it must produce.
    task automatic glob_step(input logic [1:0] rt, input logic [15:0] cc, input logic [5:0] ps,
                             input logic lst, output t_match_res res);
        int len;
        int i;
        logic [SLOTS:0] cur;
        logic [SLOTS:0] nxt;
        logic [15:0] c;
        len = (glob_len > SLOTS) ? SLOTS : int'(glob_len);
        res = '0;
        case (rt)
            REQ_LOAD: begin
                glob_pattern[ps] = cc;
            end
            REQ_QUERY: begin
                // The empty subject matches only if stars alone reach the end.
                cur = NFA_START;
                cur = star_spread(cur, len);
                res.matched = (len == 0) || cur[len];
                res.done = 1'b1;
                nfa_active = NFA_START;
            end
            REQ_SUBJECT: begin
                cur = star_spread(nfa_active, len);
                nxt = '0;
                c = to_upper(cc);
                for (i = 0; i < len; i++) begin
                    if (cur[i]) begin
                        if (glob_pattern[i] == CH_STAR) begin
                            nxt[i] = 1'b1;
                        end else if (glob_pattern[i] == CH_QMARK ||
                                     to_upper(glob_pattern[i]) == c) begin
                            nxt[i + 1] = 1'b1;
                        end
                    end
                end
                nxt = star_spread(nxt, len);
                res.matched = (len == 0) || nxt[len];
                res.done = lst;
                nfa_active = lst ? NFA_START : nxt;
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Monitors and checker
    // ------------------------------------------------------------------

    // Every accepted request goes through the predictor; a directed row with a typed
    // answer replaces the predicted one, though the predictor state still advances.
    always @(posedge clk) begin : watch_requests
        t_match_res  want;
        t_fixed_hint hint;
        if (rst_n && req_if.valid && req_if.ready) begin
            glob_step(req_if.req_type, req_if.char_code, req_if.position, req_if.last, want);
            hint = '0;
            if (fixed_hint_q.size() != 0) begin
                hint = fixed_hint_q.pop_front();
            end
            match_expect_q.push_back(hint.fixed ? hint.res : want);
        end
    end

    always @(posedge clk) begin : watch_config
        if (rst_n && cfg_valid && cfg_ready) begin
            glob_len = cfg_data;
        end
    end

    always @(posedge clk) begin : check_results
        t_match_res want;
        if (rst_n && res_if.valid && res_if.ready) begin
            results_checked++;
            if (match_expect_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t: result with no request pending: matched=%0b done=%0b",
                             $time, res_if.matched, res_if.subject_done);
                end
            end else begin
                want = match_expect_q.pop_front();
                if (res_if.matched !== want.matched) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: matched mismatch: expected %0b, got %0b",
                                 $time, want.matched, res_if.matched);
                    end
                end
                if (res_if.subject_done !== want.done) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: subject_done mismatch: expected %0b, got %0b",
                                 $time, want.done, res_if.subject_done);
                    end
                end
            end
        end
    end

    // Result receiver: random stalls at the rate of the current phase, or a long hold
    // when the stimulus asks for one so that the core backs up into its request side.
    always @(posedge clk) begin : drive_receiver
        if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // The run stops here if the core hangs.
    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: no progress after %0d cycles, %0d results still pending",
                     $time, LIMIT_CYCLES, match_expect_q.size());
            $display("case_insensitive_wildcard_matcher_core_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one request, with random idle cycles ahead of it, and hold it until taken.
    // Valid stays high on return so that back-to-back requests need no gap.
    task automatic send_request(input logic [1:0] rt, input logic [15:0] cc,
                                input logic [5:0] ps, input logic lst,
                                input logic fixed, input t_match_res fixed_res);
        t_fixed_hint hint;
        hint.fixed = fixed;
        hint.res = fixed_res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        fixed_hint_q.push_back(hint);
        req_if.valid     <= 1'b1;
        req_if.req_type  <= rt;
        req_if.char_code <= cc;
        req_if.position  <= ps;
        req_if.last      <= lst;
        do @(posedge clk); while (!req_if.ready);
        if (rt != REQ_UNUSED) begin
            requests_sent++;
        end
    endtask

    task automatic send_plain(input logic [1:0] rt, input logic [15:0] cc,
                              input logic [5:0] ps, input logic lst);
        send_request(rt, cc, ps, lst, 1'b0, '0);
    endtask

    // Stop offering and wait until every result owed by the core has been checked.
    // The first edge lets the monitor record the request taken at the current one.
    task automatic wait_results_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (match_expect_q.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // The length register is written only with the core idle.
    task automatic write_length(input logic [LEN_W-1:0] len);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Characters chosen to sit on the fold boundaries: the letters, the neighbors of
    // a..z, the wildcards as literals, Latin-1 letters, a code unit whose low byte
    // looks like a letter and random code units.
    function automatic logic [15:0] pick_char();
        case ($urandom_range(0, 11))
            0:       return CH_LOWER_A;
            1:       return CH_LOWER_Z;
            2:       return 16'h0041;
            3:       return 16'h005A;
            4:       return 16'h0060;
            5:       return 16'h007B;
            6:       return CH_STAR;
            7:       return CH_QMARK;
            8:       return 16'h00E9;
            9:       return 16'h00C9;
            10:      return 16'h0161;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Most subjects are written out from the phase pattern, with wildcards filled in
    // and ASCII letters in random case; some get one character spoiled, and the rest
    // are plain random strings.
    task automatic build_subject(input int eff);
        int i;
        int k;
        logic [15:0] p;
        subject_buf.delete();
        if (eff > 0 && $urandom_range(0, 9) < 7) begin
            for (i = 0; i < eff; i++) begin
                p = phase_pat[i];
                if (p == CH_STAR) begin
                    k = $urandom_range(0, 2);
                    repeat (k) subject_buf.push_back(pick_char());
                end else if (p == CH_QMARK) begin
                    subject_buf.push_back(pick_char());
                end else if (((p >= 16'h0041 && p <= 16'h005A) ||
                              (p >= CH_LOWER_A && p <= CH_LOWER_Z)) && $urandom_range(0, 1)) begin
                    subject_buf.push_back(p ^ CASE_OFFSET);
                end else begin
                    subject_buf.push_back(p);
                end
            end
            if (subject_buf.size() != 0 && $urandom_range(0, 3) == 0) begin
                subject_buf[$urandom_range(0, subject_buf.size() - 1)] = pick_char();
            end
        end else begin
            k = $urandom_range(1, 10);
            repeat (k) subject_buf.push_back(pick_char());
        end
    endtask

    // Stream the built subject. Now and then a stray pattern load or an unused code
    // lands in the middle, so the pattern changes under a live subject.
    task automatic send_subject(input logic terminate);
        int i;
        for (i = 0; i < subject_buf.size(); i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_plain($urandom_range(0, 1) ? REQ_LOAD : REQ_UNUSED,
                           16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)),
                           1'($urandom_range(0, 1)));
            end
            send_plain(REQ_SUBJECT, subject_buf[i], 6'($urandom_range(0, 63)),
                       terminate && (i == subject_buf.size() - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        int r;
        int i;
        int s;
        int eff;
        int n_subj;
        logic [LEN_W-1:0] len;
        logic [15:0] pc;

        rst_n = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_LOAD;
        req_if.char_code = '0;
        req_if.position  = '0;
        req_if.last      = 1'b0;
        res_if.ready     = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;

        // Directed rows. With the reset length of zero every subject and query matches.
        // Then the pattern "*a?" plus a Latin-1 letter goes in, and the table walks
        // through case folding, exact non-ASCII compare, literal wildcards in the
        // subject, a query with last set, a pattern change in mid-subject and a
        // return to the empty pattern.
        dir_tab = '{
            '{1'b0, REQ_SUBJECT, CH_LOWER_A,  6'd0,  1'b0, 1'b1, 1'b1, 1'b0},
            '{1'b0, REQ_SUBJECT, 16'hFFFF,    6'd63, 1'b1, 1'b1, 1'b1, 1'b1},
            '{1'b0, REQ_QUERY,   16'h0000,    6'd0,  1'b0, 1'b1, 1'b1, 1'b1},
            '{1'b0, REQ_UNUSED,  16'hFFFF,    6'd63, 1'b1, 1'b1, 1'b0, 1'b0},
            '{1'b0, REQ_LOAD,    CH_STAR,     6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
            '{1'b0, REQ_LOAD,    CH_LOWER_A,  6'd1,  1'b1, 1'b1, 1'b0, 1'b0},
            '{1'b0, REQ_LOAD,    CH_QMARK,    6'd2,  1'b0, 1'b1, 1'b0, 1'b0},
            '{1'b0, REQ_LOAD,    16'h00E9,    6'd3,  1'b0, 1'b1, 1'b0, 1'b0},
            '{1'b0, REQ_LOAD,    16'hFFFF,    6'd63, 1'b0, 1'b1, 1'b0, 1'b0},
            '{1'b1, REQ_LOAD,    16'd4,       6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_QUERY,   16'h0000,    6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, 16'h0041,    6'd5,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, 16'h0078,    6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, 16'h00E9,    6'd0,  1'b1, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, CH_STAR,     6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, CH_QMARK,    6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, 16'h00C9,    6'd0,  1'b1, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_QUERY,   16'h1234,    6'd21, 1'b1, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, 16'h0062,    6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_LOAD,    16'h0042,    6'd1,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, 16'h0062,    6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, 16'h007B,    6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, 16'h0000,    6'd0,  1'b1, 1'b0, 1'b0, 1'b0},
            '{1'b1, REQ_LOAD,    16'd0,       6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
            '{1'b0, REQ_SUBJECT, 16'h7FFF,    6'd0,  1'b0, 1'b1, 1'b1, 1'b0},
            '{1'b0, REQ_QUERY,   16'h0000,    6'd0,  1'b0, 1'b1, 1'b1, 1'b1}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].is_cfg) begin
                write_length(dir_tab[i].cc[LEN_W-1:0]);
            end else begin
                send_request(dir_tab[i].rt, dir_tab[i].cc, dir_tab[i].ps, dir_tab[i].lst,
                             dir_tab[i].fixed, '{dir_tab[i].em, dir_tab[i].ed});
            end
        end

        // Random traffic in phases. Each phase sets a length while idle, loads the
        // pattern slots that length uses, then sends subjects and queries. The first
        // phases hit the full length, a saturating length and the empty pattern.
        while (requests_sent < TOTAL_ITEMS) begin
            case (phase_count % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase

            case (phase_count)
                0: len = 7'd64;
                1: len = 7'd127;
                2: len = 7'd0;
                default: begin
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        len = 7'd0;
                    end else if (r == 1) begin
                        len = 7'($urandom_range(64, 127));
                    end else if (r < 4) begin
                        len = 7'($urandom_range(9, 64));
                    end else begin
                        len = 7'($urandom_range(1, 8));
                    end
                end
            endcase
            write_length(len);
            eff = (len > SLOTS) ? SLOTS : int'(len);

            // Loads come before any subject, so no slot inside the length is read unwritten.
            for (i = 0; i < eff; i++) begin
                r = $urandom_range(0, 19);
                if (r < 5) begin
                    pc = CH_STAR;
                end else if (r < 8) begin
                    pc = CH_QMARK;
                end else if (r == 8) begin
                    pc = 16'($urandom_range(0, 65535));
                end else begin
                    pc = pick_char();
                end
                phase_pat[i] = pc;
                send_plain(REQ_LOAD, pc, 6'(i), 1'($urandom_range(0, 1)));
            end

            // Phase four stalls the receiver for a long stretch while the sender keeps
            // going at full rate, so both buffer entries fill and the input backs up.
            if (phase_count == 4) begin
                hold_asks++;
            end

            n_subj = (eff > 16) ? 2 : $urandom_range(6, 12);
            for (s = 0; s < n_subj; s++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_plain(REQ_QUERY, 16'($urandom_range(0, 65535)),
                               6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
                end else begin
                    build_subject(eff);
                    // The last subject of a phase is sometimes left open, so the next
                    // length write lands in mid-subject with positions still live.
                    send_subject(!(s == n_subj - 1 && $urandom_range(0, 3) == 0));
                end
                // Phase six pauses the sender until the core has nothing left in flight.
                if (phase_count == 6 && s == n_subj / 2) begin
                    wait_results_drained();
                end
            end
            phase_count++;
        end

        wait_results_drained();
        repeat (6) @(posedge clk);

        $display("Ran %0d requests: directed table, then %0d random phases over lengths 0 to 127.",
                 requests_sent, phase_count);
        $display("Compared %0d results; %0d mismatches, %0d results still owed.",
                 results_checked, error_count, match_expect_q.size());
        if (error_count == 0 && match_expect_q.size() == 0) begin
            $display("case_insensitive_wildcard_matcher_core_tb: PASS");
        end else begin
            $display("case_insensitive_wildcard_matcher_core_tb: FAIL");
        end
        $finish;
    end

endmodule
